/* design/cpio_pkg.sv */
// cpio newc parser package: region state type, output region codes,
// magic and trailer name constants, hex digit decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpio_pkg;

	// parser region, one-hot
	typedef enum logic [6:0] {
		RG_HEADER  = 7'b0000001,
		RG_NAME    = 7'b0000010,
		RG_HPAD    = 7'b0000100,
		RG_PAYLOAD = 7'b0001000,
		RG_PPAD    = 7'b0010000,
		RG_AFTER   = 7'b0100000,
		RG_REJECT  = 7'b1000000
	} region_t;

	// region codes seen on the output
	localparam logic [2:0] CODE_HEADER  = 3'd0;
	localparam logic [2:0] CODE_NAME    = 3'd1;
	localparam logic [2:0] CODE_HPAD    = 3'd2;
	localparam logic [2:0] CODE_PAYLOAD = 3'd3;
	localparam logic [2:0] CODE_PPAD    = 3'd4;
	localparam logic [2:0] CODE_AFTER   = 3'd5;
	localparam logic [2:0] CODE_REJECT  = 3'd6;

	localparam int unsigned HDR_SIZE  = 110;
	localparam int unsigned MAGIC_LEN = 6;
	localparam int unsigned NAME_LEN  = 10;

	// held field slots
	localparam int unsigned SLOT_INODE = 0;
	localparam int unsigned SLOT_MODE  = 1;
	localparam int unsigned SLOT_MTIME = 2;
	localparam int unsigned SLOT_SIZE  = 3;
	localparam int unsigned SLOT_NAMES = 4;
	localparam int unsigned SLOT_CHECK = 5;
	localparam int unsigned NUM_SLOTS  = 6;

	// header hex field index of each held slot
	localparam logic [3:0] FIELD_INODE = 4'd0;
	localparam logic [3:0] FIELD_MODE  = 4'd1;
	localparam logic [3:0] FIELD_MTIME = 4'd5;
	localparam logic [3:0] FIELD_SIZE  = 4'd6;
	localparam logic [3:0] FIELD_NAMES = 4'd11;
	localparam logic [3:0] FIELD_CHECK = 4'd12;

	localparam logic [7:0] MAGIC_PREFIX [5] = '{8'h30, 8'h37, 8'h30, 8'h37, 8'h30};
	localparam logic [7:0] MAGIC_NEWC = 8'h31;
	localparam logic [7:0] MAGIC_CRC  = 8'h32;

	localparam logic [7:0] TRAILER_TEXT [NAME_LEN] = '{
		8'h54, 8'h52, 8'h41, 8'h49, 8'h4C, 8'h45, 8'h52, 8'h21, 8'h21, 8'h21
	};

	localparam int unsigned TDATA_W = 200;

	// ascii hex digit to value, anything else reads as zero
	function automatic logic [3:0] hex_nibble(input logic [7:0] b);
		logic [3:0] v;
		v = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			v = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			v = 4'(b - 8'h37);
		end
		return v;
	endfunction

	// one-hot region to output code
	function automatic logic [2:0] region_code(input region_t r);
		logic [2:0] code;
		unique case (r)
			RG_HEADER:  code = CODE_HEADER;
			RG_NAME:    code = CODE_NAME;
			RG_HPAD:    code = CODE_HPAD;
			RG_PAYLOAD: code = CODE_PAYLOAD;
			RG_PPAD:    code = CODE_PPAD;
			RG_AFTER:   code = CODE_AFTER;
			default:    code = CODE_REJECT;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

/* design/cpio_newc_entry_parser.sv */
// cpio newc entry parser: tags each archive byte with its region and
// decodes the header fields. Depends on cpio_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one archive byte per item and gives one result item per byte, one
// item per clock cycle sustained while m_tready keeps the result stage free.
// A byte is held in the input register; its region, flags and the field
// values are worked out from the parser state and land in the result register.
// The rate is set by the parser state update (region counter, hex shift
// register and held fields), which takes one byte each cycle unless the
// result register is stalled. tuser on the input is the start flag that
// restarts the parser on that byte; m_tlast marks the last byte of an entry and m_tuser gives the region code.
module cpio_newc_entry_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,   // [7:0] data_byte
	input  wire logic                           s_tuser,   // [0] start_flag
	// result stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [0] header_done, [1] crc_format, [2] is_trailer, [3] error_code,
	// [35:4] inode_out, [67:36] mode_out, [99:68] mtime_out,
	// [131:100] payload_size, [163:132] name_length, [195:164] check_out
	output logic [cpio_pkg::TDATA_W-1:0]        m_tdata,
	output logic                                m_tlast,   // entry_end
	output logic [2:0]                          m_tuser    // [2:0] region
);
	import cpio_pkg::*;

	// parser state
	region_t     region_q;
	logic [31:0] count_q;
	logic [31:0] acc_q;
	logic [31:0] fld_q [NUM_SLOTS];
	logic        fmt_q;
	logic        tmatch_q;
	logic        tseen_q;
	logic [1:0]  hlow_q;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	// result stage
	logic                 valid_s2;
	logic [TDATA_W-1:0]   data_s2;
	logic                 last_s2;
	logic [2:0]           user_s2;

	logic out_free;
	logic advance;

	// next state and result
	region_t     r_cur, n_r;
	logic [31:0] c_cur, n_c, n_acc, acc_cur;
	logic [31:0] f_cur [NUM_SLOTS];
	logic [31:0] n_fld [NUM_SLOTS];
	logic        fmt_cur, n_fmt, tm_cur, n_tm, ts_cur, n_ts;
	logic [1:0]  hl_cur, n_hl;
	logic [2:0]  reg_o;
	logic        eend, hdone, err;
	logic        do_finish, do_payload, do_ppad;
	logic        magic_ok;
	logic [31:0] hdr_off;
	logic [3:0]  field_k;
	logic [1:0]  hpad, ppad;

	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// parse one byte
	always_comb begin
		// start flag clears everything before the byte is looked at
		if (start_s1) begin
			r_cur   = RG_HEADER;
			c_cur   = '0;
			acc_cur = '0;
			for (int i = 0; i < NUM_SLOTS; i++) f_cur[i] = '0;
			fmt_cur = 1'b0;
			tm_cur  = 1'b1;
			ts_cur  = 1'b0;
			hl_cur  = 2'd0;
		end else begin
			r_cur   = region_q;
			c_cur   = count_q;
			acc_cur = acc_q;
			for (int i = 0; i < NUM_SLOTS; i++) f_cur[i] = fld_q[i];
			fmt_cur = fmt_q;
			tm_cur  = tmatch_q;
			ts_cur  = tseen_q;
			hl_cur  = hlow_q;
		end

		n_r   = r_cur;
		n_c   = c_cur;
		n_acc = acc_cur;
		for (int i = 0; i < NUM_SLOTS; i++) n_fld[i] = f_cur[i];
		n_fmt = fmt_cur;
		n_tm  = tm_cur;
		n_ts  = ts_cur;
		n_hl  = hl_cur;
		reg_o = region_code(r_cur);
		eend  = 1'b0;
		hdone = 1'b0;
		err   = 1'b0;
		do_finish  = 1'b0;
		do_payload = 1'b0;
		do_ppad    = 1'b0;
		magic_ok   = 1'b0;
		hdr_off    = c_cur - 32'(MAGIC_LEN);
		field_k    = hdr_off[6:3];

		unique case (r_cur)
			RG_HEADER: begin
				if (c_cur < 32'(MAGIC_LEN)) begin
					if (c_cur < 32'(MAGIC_LEN - 1))
						magic_ok = (byte_s1 == MAGIC_PREFIX[c_cur[2:0]]);
					else
						magic_ok = (byte_s1 == MAGIC_NEWC) || (byte_s1 == MAGIC_CRC);
					if (!magic_ok) begin
						n_r   = RG_REJECT;
						reg_o = CODE_REJECT;
						err   = 1'b1;
					end else begin
						if (c_cur == 32'(MAGIC_LEN - 1))
							n_fmt = (byte_s1 == MAGIC_CRC);
						n_c = c_cur + 32'd1;
					end
				end else begin
					n_acc = {acc_cur[27:0], hex_nibble(byte_s1)};
					// eighth digit of a field completes it
					if (hdr_off[2:0] == 3'd7) begin
						case (field_k)
							FIELD_INODE: n_fld[SLOT_INODE] = n_acc;
							FIELD_MODE:  n_fld[SLOT_MODE]  = n_acc;
							FIELD_MTIME: n_fld[SLOT_MTIME] = n_acc;
							FIELD_SIZE:  n_fld[SLOT_SIZE]  = n_acc;
							FIELD_NAMES: n_fld[SLOT_NAMES] = n_acc;
							FIELD_CHECK: n_fld[SLOT_CHECK] = n_acc;
							default: ;
						endcase
						n_acc = '0;
					end
					if (c_cur >= 32'(HDR_SIZE - 1)) begin
						n_tm = 1'b1;
						n_hl = 2'(HDR_SIZE) + n_fld[SLOT_NAMES][1:0];
						if (n_fld[SLOT_NAMES] == '0) begin
							// empty name ends on the header
							n_tm      = 1'b0;
							hdone     = 1'b1;
							do_finish = 1'b1;
						end else begin
							n_r = RG_NAME;
							n_c = '0;
						end
					end else begin
						n_c = c_cur + 32'd1;
					end
				end
			end
			RG_NAME: begin
				if (c_cur < 32'(NAME_LEN)) begin
					if (byte_s1 != TRAILER_TEXT[c_cur[3:0]]) n_tm = 1'b0;
				end else if (c_cur == 32'(NAME_LEN)) begin
					if (byte_s1 != 8'h00) n_tm = 1'b0;
				end
				if (c_cur == f_cur[SLOT_NAMES] - 32'd1) begin
					hdone     = 1'b1;
					do_finish = 1'b1;
				end else begin
					n_c = c_cur + 32'd1;
				end
			end
			RG_HPAD: begin
				n_c = c_cur + 32'd1;
				if (n_c >= {30'd0, 2'(2'd0 - hl_cur)}) do_payload = 1'b1;
			end
			RG_PAYLOAD: begin
				n_c = c_cur + 32'd1;
				if (n_c == f_cur[SLOT_SIZE]) do_ppad = 1'b1;
			end
			RG_PPAD: begin
				n_c = c_cur + 32'd1;
				if (n_c >= {30'd0, 2'(2'd0 - f_cur[SLOT_SIZE][1:0])}) begin
					n_r  = RG_HEADER;
					n_c  = '0;
					n_tm = 1'b1;
					eend = 1'b1;
				end
			end
			RG_AFTER: ;
			default: begin
				reg_o = CODE_REJECT;
				err   = 1'b1;
			end
		endcase

		// end of name: trailer check or header padding
		hpad = 2'd0 - n_hl;
		if (do_finish) begin
			n_c = '0;
			if (n_tm && n_fld[SLOT_NAMES] >= 32'(NAME_LEN)) begin
				n_ts = 1'b1;
				n_r  = RG_AFTER;
			end else if (hpad != 2'd0) begin
				n_r = RG_HPAD;
			end else begin
				do_payload = 1'b1;
			end
		end

		// payload, skipped when empty
		if (do_payload) begin
			n_c = '0;
			if (n_fld[SLOT_SIZE] != '0) n_r = RG_PAYLOAD;
			else do_ppad = 1'b1;
		end

		// payload padding, skipped when empty
		ppad = 2'd0 - n_fld[SLOT_SIZE][1:0];
		if (do_ppad) begin
			n_c = '0;
			if (ppad != 2'd0) begin
				n_r = RG_PPAD;
			end else begin
				n_r  = RG_HEADER;
				n_tm = 1'b1;
				eend = 1'b1;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// parser state update, once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= RG_HEADER;
			count_q  <= '0;
			acc_q    <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) fld_q[i] <= '0;
			fmt_q    <= 1'b0;
			tmatch_q <= 1'b1;
			tseen_q  <= 1'b0;
			hlow_q   <= 2'd0;
		end else if (advance) begin
			region_q <= n_r;
			count_q  <= n_c;
			acc_q    <= n_acc;
			for (int i = 0; i < NUM_SLOTS; i++) fld_q[i] <= n_fld[i];
			fmt_q    <= n_fmt;
			tmatch_q <= n_tm;
			tseen_q  <= n_ts;
			hlow_q   <= n_hl;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {4'd0, n_fld[SLOT_CHECK], n_fld[SLOT_NAMES], n_fld[SLOT_SIZE],
				n_fld[SLOT_MTIME], n_fld[SLOT_MODE], n_fld[SLOT_INODE],
				err, n_ts, n_fmt, hdone};
			last_s2 <= eend;
			user_s2 <= reg_o;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tlast  = last_s2;
	assign m_tuser  = user_s2;

endmodule

`default_nettype wire
